// ----- rtl/rbgs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbgs_pkg
// Shared sizes, codes, types and saturation helpers of the red-black
// Gauss-Seidel Poisson brick smoother.
// ----------------------------------------------------------------------------
package rbgs_pkg;

    // brick geometry
    localparam int BRICK_SIZE = 8;
    localparam int DIM        = BRICK_SIZE + 2;
    localparam int SOL_DEPTH  = DIM * DIM * DIM;
    localparam int RHS_DEPTH  = BRICK_SIZE * BRICK_SIZE * BRICK_SIZE;
    localparam int SOL_AW     = $clog2(SOL_DEPTH);
    localparam int RHS_AW     = $clog2(RHS_DEPTH);
    localparam int CRD_BITS   = $clog2(BRICK_SIZE);
    localparam int PAD_BITS   = $clog2(DIM);

    // port field widths
    localparam int CMD_BITS      = 3;
    localparam int IN_CRD_BITS   = 5;
    localparam int IN_VALUE_BITS = 32;
    localparam int DATA_BITS     = 32;

    // stored value and datapath widths
    localparam int VALUE_BITS = 32;
    localparam int ACC_BITS   = VALUE_BITS + 4;
    localparam int MAG_BITS   = VALUE_BITS + 2;
    localparam int LO_BITS    = MAG_BITS / 2;
    localparam int HI_BITS    = MAG_BITS - LO_BITS;

    // divide by six as multiply by a rounded-up reciprocal
    localparam int DIV_SHIFT  = MAG_BITS + 3;
    localparam int RECIP_BITS = DIV_SHIFT - 2;
    localparam logic [63:0] DIV_RECIP = ((64'd1 << DIV_SHIFT) + 64'd5) / 64'd6;

    localparam logic signed [63:0] VAL_MAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] VAL_MIN = -VAL_MAX - 64'sd1;
    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (DATA_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

    typedef logic signed [VALUE_BITS-1:0] t_val;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WRITE_CELL    = 3'd0,
        CMD_WRITE_RHS     = 3'd1,
        CMD_SWEEP         = 3'd2,
        CMD_READ_CELL     = 3'd3,
        CMD_READ_RESIDUAL = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDWAIT,
        ST_GATHER,
        ST_DRAIN,
        ST_RESFIN,
        ST_ABS,
        ST_MUL,
        ST_SUM,
        ST_WB,
        ST_RESP
    } t_state;

    // clamp to the stored value range
    function automatic t_val sat_to_val(input logic signed [63:0] v);
        t_val res;
        if (v > VAL_MAX) begin
            res = VAL_MAX[VALUE_BITS-1:0];
        end else if (v < VAL_MIN) begin
            res = VAL_MIN[VALUE_BITS-1:0];
        end else begin
            res = v[VALUE_BITS-1:0];
        end
        return res;
    endfunction

    // clamp to the result data range
    function automatic logic [DATA_BITS-1:0] sat_to_out(input logic signed [63:0] v);
        logic [DATA_BITS-1:0] res;
        if (v > OUT_MAX) begin
            res = OUT_MAX[DATA_BITS-1:0];
        end else if (v < OUT_MIN) begin
            res = OUT_MIN[DATA_BITS-1:0];
        end else begin
            res = v[DATA_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/rbgs_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbgs_cmd_if
// Command channel: valid/ready handshake with command, cell and value fields.
// ----------------------------------------------------------------------------
interface rbgs_cmd_if;
    import rbgs_pkg::*;

    logic                            valid;
    logic                            ready;
    logic [CMD_BITS-1:0]             cmd;
    logic signed [IN_CRD_BITS-1:0]   x;
    logic signed [IN_CRD_BITS-1:0]   y;
    logic signed [IN_CRD_BITS-1:0]   z;
    logic signed [IN_VALUE_BITS-1:0] value;
    logic                            parity;

    modport source (output valid, cmd, x, y, z, value, parity, input ready);
    modport sink   (input valid, cmd, x, y, z, value, parity, output ready);

endinterface

// ----- rtl/rbgs_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbgs_rsp_if
// Response channel: valid/ready handshake with data and error fields.
// ----------------------------------------------------------------------------
interface rbgs_rsp_if;
    import rbgs_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] data;
    logic                        error;

    modport source (output valid, data, error, input ready);
    modport sink   (input valid, data, error, output ready);

endinterface

// ----- rtl/brick_red_black_poisson_smoother_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brick_red_black_poisson_smoother_top
// One 8x8x8 Poisson brick with halo: cell and rhs access, red-black
// Gauss-Seidel half-sweeps and 7-point residual reads.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per transaction (write cell, write rhs,
//   half-sweep, read cell, read residual); o_rsp returns exactly one
//   transaction per command, in order, with data and an error flag.
//   Commands are worked one at a time; a finished result sits in the
//   output register, so the next command is taken while it waits.
//   A residual read makes seven solution memory reads; a half-sweep updates
//   256 cells. A swept cell costs six reads and one write-back on the single
//   solution memory port plus a drain state and the divide by six (abs,
//   split reciprocal multiply, sum).
//   After reset a clearing pass zeroes both memories; no command is taken
//   until it ends. When the receiver stalls, the result holds in the output
//   register and the following result waits inside.
// ----------------------------------------------------------------------------
module brick_red_black_poisson_smoother_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbgs_cmd_if.sink    i_cmd,
    rbgs_rsp_if.source  o_rsp
);
    import rbgs_pkg::*;

    localparam logic [2:0] TAP_XM  = 3'd0;
    localparam logic [2:0] TAP_XP  = 3'd1;
    localparam logic [2:0] TAP_YM  = 3'd2;
    localparam logic [2:0] TAP_YP  = 3'd3;
    localparam logic [2:0] TAP_ZM  = 3'd4;
    localparam logic [2:0] TAP_ZP  = 3'd5;
    localparam logic [2:0] TAP_CTR = 3'd6;

    localparam int PLO_BITS  = LO_BITS + RECIP_BITS;
    localparam int PHI_BITS  = HI_BITS + RECIP_BITS;
    localparam int PROD_BITS = MAG_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP = DIV_RECIP[RECIP_BITS-1:0];

    localparam logic signed [IN_CRD_BITS:0] HALO_LO  = (IN_CRD_BITS + 1)'(-1);
    localparam logic signed [IN_CRD_BITS:0] HALO_HI  = (IN_CRD_BITS + 1)'(BRICK_SIZE);
    localparam logic signed [IN_CRD_BITS:0] INNER_HI = (IN_CRD_BITS + 1)'(BRICK_SIZE - 1);
    localparam logic [CRD_BITS-1:0]         CRD_LAST = CRD_BITS'(BRICK_SIZE - 1);

    // address helpers
    function automatic logic [SOL_AW-1:0] sol_addr(input logic [PAD_BITS-1:0] px,
                                                   input logic [PAD_BITS-1:0] py,
                                                   input logic [PAD_BITS-1:0] pz);
        return SOL_AW'(px) + SOL_AW'(DIM) * SOL_AW'(py) + SOL_AW'(DIM * DIM) * SOL_AW'(pz);
    endfunction

    function automatic logic [RHS_AW-1:0] rhs_addr(input logic [CRD_BITS-1:0] cx,
                                                   input logic [CRD_BITS-1:0] cy,
                                                   input logic [CRD_BITS-1:0] cz);
        return RHS_AW'(cx) + RHS_AW'(BRICK_SIZE) * RHS_AW'(cy)
             + RHS_AW'(BRICK_SIZE * BRICK_SIZE) * RHS_AW'(cz);
    endfunction

    function automatic logic halo_rng(input logic signed [IN_CRD_BITS:0] v);
        return (v >= HALO_LO) && (v <= HALO_HI);
    endfunction

    function automatic logic inner_rng(input logic signed [IN_CRD_BITS:0] v);
        return !v[IN_CRD_BITS] && (v <= INNER_HI);
    endfunction

    // state and control registers
    t_state              r_state, n_state;
    logic [SOL_AW-1:0]   r_clr_addr;
    logic                r_out_valid;
    logic                r_pend_vld;

    // datapath registers
    logic [2:0]                 r_tap;
    logic [2:0]                 r_pend_tap;
    logic                       r_is_res;
    logic                       r_par;
    logic [CRD_BITS-1:0]        r_ci, r_cj, r_ck;
    logic signed [ACC_BITS-1:0] r_acc;
    logic [MAG_BITS-1:0]        r_mag;
    logic                       r_neg;
    logic [PLO_BITS-1:0]        r_plo;
    logic [PHI_BITS-1:0]        r_phi;
    logic [VALUE_BITS-1:0]      r_q;
    logic [DATA_BITS-1:0]       r_res_data;
    logic                       r_res_err;
    logic [DATA_BITS-1:0]       r_out_data;
    logic                       r_out_err;

    // memories
    logic [VALUE_BITS-1:0] r_sol_mem [SOL_DEPTH];
    logic [VALUE_BITS-1:0] r_rhs_mem [RHS_DEPTH];
    t_val                  r_sol_q;
    t_val                  r_rhs_q;

    // memory port controls
    logic              sol_we;
    logic [SOL_AW-1:0] sol_ad;
    t_val              sol_wdata;
    logic              rhs_we;
    logic [RHS_AW-1:0] rhs_ad;
    t_val              rhs_wdata;
    logic              in_ready;
    logic              out_load;

    // command decode
    logic                          cmd_accept;
    logic signed [IN_CRD_BITS:0]   in_xe, in_ye, in_ze;
    logic [IN_CRD_BITS:0]          in_xp, in_yp, in_zp;
    logic                          halo_ok, inner_ok, in_err;
    logic [SOL_AW-1:0]             in_sol_ad;
    logic [RHS_AW-1:0]             in_rhs_ad;
    t_val                          in_val;

    assign cmd_accept = i_cmd.valid && in_ready;
    assign in_xe      = (IN_CRD_BITS + 1)'(i_cmd.x);
    assign in_ye      = (IN_CRD_BITS + 1)'(i_cmd.y);
    assign in_ze      = (IN_CRD_BITS + 1)'(i_cmd.z);
    assign in_xp      = in_xe + (IN_CRD_BITS + 1)'(1);
    assign in_yp      = in_ye + (IN_CRD_BITS + 1)'(1);
    assign in_zp      = in_ze + (IN_CRD_BITS + 1)'(1);
    assign halo_ok    = halo_rng(in_xe) && halo_rng(in_ye) && halo_rng(in_ze);
    assign inner_ok   = inner_rng(in_xe) && inner_rng(in_ye) && inner_rng(in_ze);
    assign in_sol_ad  = sol_addr(in_xp[PAD_BITS-1:0], in_yp[PAD_BITS-1:0],
                                 in_zp[PAD_BITS-1:0]);
    assign in_rhs_ad  = rhs_addr(in_xe[CRD_BITS-1:0], in_ye[CRD_BITS-1:0],
                                 in_ze[CRD_BITS-1:0]);
    assign in_val     = sat_to_val(64'(i_cmd.value));

    // coordinate range check per command
    always_comb begin
        unique case (i_cmd.cmd) inside
            CMD_WRITE_CELL, CMD_READ_CELL:    in_err = !halo_ok;
            CMD_WRITE_RHS, CMD_READ_RESIDUAL: in_err = !inner_ok;
            CMD_SWEEP:                        in_err = 1'b0;
            default:                          in_err = 1'b1;
        endcase
    end

    // neighbour tap address around the current center
    logic [PAD_BITS-1:0] cpx, cpy, cpz, tpx, tpy, tpz;
    logic [SOL_AW-1:0]   tap_ad, ctr_ad;
    logic [RHS_AW-1:0]   ctr_rhs_ad;
    logic                last_tap;

    assign cpx = PAD_BITS'(r_ci) + PAD_BITS'(1);
    assign cpy = PAD_BITS'(r_cj) + PAD_BITS'(1);
    assign cpz = PAD_BITS'(r_ck) + PAD_BITS'(1);

    always_comb begin
        tpx = cpx;
        tpy = cpy;
        tpz = cpz;
        case (r_tap)
            TAP_XM:  tpx = cpx - PAD_BITS'(1);
            TAP_XP:  tpx = cpx + PAD_BITS'(1);
            TAP_YM:  tpy = cpy - PAD_BITS'(1);
            TAP_YP:  tpy = cpy + PAD_BITS'(1);
            TAP_ZM:  tpz = cpz - PAD_BITS'(1);
            TAP_ZP:  tpz = cpz + PAD_BITS'(1);
            default: ;
        endcase
    end

    assign tap_ad     = sol_addr(tpx, tpy, tpz);
    assign ctr_ad     = sol_addr(cpx, cpy, cpz);
    assign ctr_rhs_ad = rhs_addr(r_ci, r_cj, r_ck);
    assign last_tap   = r_is_res ? (r_tap == TAP_CTR) : (r_tap == TAP_ZP);

    // next cell of the chosen colour
    logic [CRD_BITS:0]   ni;
    logic                row_end, last_cell;
    logic [CRD_BITS-1:0] nj, nk;
    logic                n_start;

    assign ni        = (CRD_BITS + 1)'(r_ci) + (CRD_BITS + 1)'(2);
    assign row_end   = ni >= (CRD_BITS + 1)'(BRICK_SIZE);
    assign last_cell = row_end && (r_cj == CRD_LAST) && (r_ck == CRD_LAST);
    assign nj        = (r_cj == CRD_LAST) ? '0 : r_cj + CRD_BITS'(1);
    assign nk        = (r_cj == CRD_LAST) ? r_ck + CRD_BITS'(1) : r_ck;
    assign n_start   = nj[0] ^ nk[0] ^ r_par;

    // accumulate term and sweep result
    logic signed [ACC_BITS-1:0]   sol_ext, ctr6, acc_base, acc_term;
    logic [PROD_BITS-1:0]         prod;
    logic signed [VALUE_BITS:0]   q_signed;
    t_val                         sweep_val;

    assign sol_ext  = ACC_BITS'(r_sol_q);
    assign ctr6     = (sol_ext <<< 2) + (sol_ext <<< 1);
    assign acc_term = (r_pend_tap == TAP_CTR) ? -ctr6 : sol_ext;
    assign acc_base = (r_pend_tap == TAP_XM) ? ACC_BITS'(r_rhs_q) : r_acc;
    assign prod     = (PROD_BITS'(r_phi) << LO_BITS) + PROD_BITS'(r_plo);
    assign q_signed = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign sweep_val = sat_to_val(64'(q_signed));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == SOL_AW'(SOL_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (cmd_accept) begin
                    if (in_err) begin
                        n_state = ST_RESP;
                    end else begin
                        unique case (i_cmd.cmd) inside
                            CMD_SWEEP, CMD_READ_RESIDUAL: n_state = ST_GATHER;
                            CMD_READ_CELL:                n_state = ST_RDWAIT;
                            default:                      n_state = ST_RESP;
                        endcase
                    end
                end
            end
            ST_RDWAIT: n_state = ST_RESP;
            ST_GATHER: begin
                if (last_tap) n_state = ST_DRAIN;
            end
            ST_DRAIN:  n_state = r_is_res ? ST_RESFIN : ST_ABS;
            ST_RESFIN: n_state = ST_RESP;
            ST_ABS:    n_state = ST_MUL;
            ST_MUL:    n_state = ST_SUM;
            ST_SUM:    n_state = ST_WB;
            ST_WB:     n_state = last_cell ? ST_RESP : ST_GATHER;
            ST_RESP: begin
                if (!r_out_valid || o_rsp.ready) n_state = ST_IDLE;
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        sol_we    = 1'b0;
        sol_ad    = tap_ad;
        sol_wdata = '0;
        rhs_we    = 1'b0;
        rhs_ad    = ctr_rhs_ad;
        rhs_wdata = '0;
        in_ready  = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                sol_we = 1'b1;
                sol_ad = r_clr_addr;
                rhs_we = r_clr_addr < SOL_AW'(RHS_DEPTH);
                rhs_ad = r_clr_addr[RHS_AW-1:0];
            end
            ST_IDLE: begin
                in_ready  = 1'b1;
                sol_ad    = in_sol_ad;
                sol_wdata = in_val;
                rhs_ad    = in_rhs_ad;
                rhs_wdata = in_val;
                if (cmd_accept && !in_err) begin
                    sol_we = i_cmd.cmd == CMD_WRITE_CELL;
                    rhs_we = i_cmd.cmd == CMD_WRITE_RHS;
                end
            end
            ST_WB: begin
                sol_we    = 1'b1;
                sol_ad    = ctr_ad;
                sol_wdata = sweep_val;
            end
            ST_RESP: begin
                out_load = !r_out_valid || o_rsp.ready;
            end
            default: ;
        endcase
    end

    // solution memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (sol_we) r_sol_mem[sol_ad] <= sol_wdata;
        r_sol_q <= r_sol_mem[sol_ad];
    end

    // rhs memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (rhs_we) r_rhs_mem[rhs_ad] <= rhs_wdata;
        r_rhs_q <= r_rhs_mem[rhs_ad];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_pend_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= r_state == ST_GATHER;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + SOL_AW'(1);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pend_tap <= r_tap;

        // gather: sum neighbours and rhs, minus six times the center for a residual, as reads come back
        if (r_pend_vld) r_acc <= acc_base + acc_term;

        unique case (r_state)
            ST_IDLE: begin
                if (cmd_accept) begin
                    r_res_data <= '0;
                    r_res_err  <= in_err;
                    r_tap      <= TAP_XM;
                    r_par      <= i_cmd.parity;
                    r_is_res   <= i_cmd.cmd == CMD_READ_RESIDUAL;
                    if (i_cmd.cmd == CMD_SWEEP) begin
                        r_ci <= CRD_BITS'(i_cmd.parity);
                        r_cj <= '0;
                        r_ck <= '0;
                    end else begin
                        r_ci <= in_xe[CRD_BITS-1:0];
                        r_cj <= in_ye[CRD_BITS-1:0];
                        r_ck <= in_ze[CRD_BITS-1:0];
                    end
                end
            end
            ST_RDWAIT: r_res_data <= sat_to_out(64'(r_sol_q));
            ST_GATHER: r_tap <= r_tap + 3'd1;
            ST_RESFIN: r_res_data <= sat_to_out(64'(sat_to_val(64'(r_acc))));
            ST_ABS: begin
                r_mag <= MAG_BITS'(r_acc[ACC_BITS-1] ? -r_acc : r_acc);
                r_neg <= r_acc[ACC_BITS-1];
            end
            ST_MUL: begin
                r_plo <= PLO_BITS'(r_mag[LO_BITS-1:0]) * PLO_BITS'(RECIP);
                r_phi <= PHI_BITS'(r_mag[MAG_BITS-1:LO_BITS]) * PHI_BITS'(RECIP);
            end
            ST_SUM: r_q <= prod[DIV_SHIFT +: VALUE_BITS];
            ST_WB: begin
                r_tap <= TAP_XM;
                if (!row_end) begin
                    r_ci <= ni[CRD_BITS-1:0];
                end else begin
                    r_ci <= CRD_BITS'(n_start);
                    r_cj <= nj;
                    r_ck <= nk;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_out_data <= r_res_data;
            r_out_err  <= r_res_err;
        end
    end

    assign i_cmd.ready = in_ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;
    assign o_rsp.error = r_out_err;

`ifndef SYNTHESIS
    // a sweep writes back only interior cells of the chosen colour
    a_wb_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB) |-> ((r_ci[0] ^ r_cj[0] ^ r_ck[0]) == r_par))
        else $error("sweep write-back on a cell of the wrong colour");

    // the center term is summed only for a residual
    a_ctr_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_vld && (r_pend_tap == TAP_CTR)) |-> r_is_res)
        else $error("center tap summed during a sweep");

    // an error result never carries data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_data == '0))
        else $error("error result with nonzero data");

    // no result is produced during the clearing pass
    a_clear_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> (r_out_valid == 1'b0))
        else $error("result produced during the clearing pass");
`endif

endmodule

// ----- sim/brick_red_black_poisson_smoother_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brick_red_black_poisson_smoother_top_tb
// Self-checking bench for the red-black Poisson brick smoother. A directed
// burst hits the value extremes, halo corners, saturation of a sweep and of
// a residual, several out-of-range cases and the unused command codes; a long
// random run then mixes cell and rhs writes, reads, residual reads and
// half-sweeps. A scoreboard keeps its own copy of both stores, predicts each
// response and compares it with what the block returns, in order.
// ----------------------------------------------------------------------------
module brick_red_black_poisson_smoother_top_tb;
    import rbgs_pkg::*;

    localparam int RANDOM_ITEMS = 265;
    localparam int HOLD_CYCLES  = 320;
    localparam int BURST_ITEMS  = 16;
    localparam int DRAIN_CYCLES = 50;
    localparam int MAX_REPORTS  = 10;

    // command codes the block does not know
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI = 3'd7;

    localparam logic signed [IN_VALUE_BITS-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [IN_VALUE_BITS-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct {
        logic [CMD_BITS-1:0]             op;
        logic signed [IN_CRD_BITS-1:0]   x;
        logic signed [IN_CRD_BITS-1:0]   y;
        logic signed [IN_CRD_BITS-1:0]   z;
        logic signed [IN_VALUE_BITS-1:0] value;
        logic                            parity;
    } t_command;

    typedef struct {
        logic signed [DATA_BITS-1:0] data;
        logic                        error;
    } t_response;

    // brick state mirror, response prediction and in-order checking
    class smoother_scoreboard;
        longint    sol_cells[SOL_DEPTH];
        longint    rhs_cells[RHS_DEPTH];
        t_response awaited[$];
        int        op_count[8];
        int        error_count;
        int        mismatches;
        int        reported;

        function int sol_at(int x, int y, int z);
            return (x + 1) + DIM * ((y + 1) + DIM * (z + 1));
        endfunction

        function int rhs_at(int x, int y, int z);
            return x + BRICK_SIZE * (y + BRICK_SIZE * z);
        endfunction

        function longint clamp_value(longint v);
            if (v > VAL_MAX) begin
                return VAL_MAX;
            end
            if (v < VAL_MIN) begin
                return VAL_MIN;
            end
            return v;
        endfunction

        function longint neighbour_total(int x, int y, int z);
            return sol_cells[sol_at(x - 1, y, z)] + sol_cells[sol_at(x + 1, y, z)]
                 + sol_cells[sol_at(x, y - 1, z)] + sol_cells[sol_at(x, y + 1, z)]
                 + sol_cells[sol_at(x, y, z - 1)] + sol_cells[sol_at(x, y, z + 1)];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // update the mirror and queue the response this command must give
        function void note_command(t_command c);
            int        xi;
            int        yi;
            int        zi;
            bit        halo_ok;
            bit        inner_ok;
            longint    acc;
            t_response rsp;
            xi = c.x;
            yi = c.y;
            zi = c.z;
            halo_ok  = (xi >= -1 && xi <= BRICK_SIZE) && (yi >= -1 && yi <= BRICK_SIZE)
                    && (zi >= -1 && zi <= BRICK_SIZE);
            inner_ok = (xi >= 0 && xi < BRICK_SIZE) && (yi >= 0 && yi < BRICK_SIZE)
                    && (zi >= 0 && zi < BRICK_SIZE);
            acc = 0;
            rsp.error = 1'b0;
            op_count[c.op]++;
            case (c.op)
                CMD_WRITE_CELL: begin
                    if (halo_ok) sol_cells[sol_at(xi, yi, zi)] = clamp_value(c.value);
                    else rsp.error = 1'b1;
                end
                CMD_WRITE_RHS: begin
                    if (inner_ok) rhs_cells[rhs_at(xi, yi, zi)] = clamp_value(c.value);
                    else rsp.error = 1'b1;
                end
                CMD_SWEEP: begin
                    // same-colour cells never touch, so visiting order is free
                    for (int k = 0; k < BRICK_SIZE; k++) begin
                        for (int j = 0; j < BRICK_SIZE; j++) begin
                            for (int i = 0; i < BRICK_SIZE; i++) begin
                                longint s;
                                if (((i + j + k) & 1) != int'(c.parity)) continue;
                                s = neighbour_total(i, j, k) + rhs_cells[rhs_at(i, j, k)];
                                sol_cells[sol_at(i, j, k)] = clamp_value(s / 6);
                            end
                        end
                    end
                end
                CMD_READ_CELL: begin
                    if (halo_ok) acc = sol_cells[sol_at(xi, yi, zi)];
                    else rsp.error = 1'b1;
                end
                CMD_READ_RESIDUAL: begin
                    if (inner_ok) begin
                        acc = rhs_cells[rhs_at(xi, yi, zi)]
                            - (6 * sol_cells[sol_at(xi, yi, zi)] - neighbour_total(xi, yi, zi));
                        acc = clamp_value(acc);
                    end else begin
                        rsp.error = 1'b1;
                    end
                end
                default: begin
                    rsp.error = 1'b1;
                end
            endcase
            rsp.data = acc[DATA_BITS-1:0];
            awaited.push_back(rsp);
        endfunction

        // compare one response transaction with the oldest prediction
        function void check_response(logic signed [DATA_BITS-1:0] data, logic error);
            t_response want;
            if (error === 1'b1) error_count++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("unexpected response: data=%0d error=%b", data, error);
                end
                return;
            end
            want = awaited.pop_front();
            if (data !== want.data || error !== want.error) begin
                mismatches++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("response mismatch: expected data=%0d error=%b, got data=%0d error=%b",
                             want.data, want.error, data, error);
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rbgs_cmd_if cmd_if ();
    rbgs_rsp_if rsp_if ();

    smoother_scoreboard sb = new();

    // stimulus to receiver signalling
    bit hold_request = 1'b0;
    bit no_idle      = 1'b0;
    int holds_done   = 0;

    brick_red_black_poisson_smoother_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // sender idle length, mostly short
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // coordinate, mostly in the command's range, sometimes any 5-bit code
    function automatic logic signed [IN_CRD_BITS-1:0] random_coord(bit with_halo);
        int r;
        r = $urandom_range(0, 99);
        if (r < 90) begin
            if (with_halo) return IN_CRD_BITS'(int'($urandom_range(0, DIM - 1)) - 1);
            return IN_CRD_BITS'($urandom_range(0, BRICK_SIZE - 1));
        end
        return IN_CRD_BITS'($urandom_range(0, 31));
    endfunction

    function automatic logic signed [IN_VALUE_BITS-1:0] random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return $urandom;
        if (r < 75) return int'($urandom_range(0, 524288)) - 262144;
        if (r < 90) begin
            case ($urandom_range(0, 4))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return 32'sd1;
                3:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return (int'($urandom_range(0, 16)) - 8) <<< 16;
    endfunction

    function automatic t_command random_command(bit allow_sweep);
        t_command c;
        int       r;
        r = $urandom_range(0, 99);
        if (!allow_sweep && r >= 50 && r < 55) r = 60;
        if (r < 30) c.op = CMD_WRITE_CELL;
        else if (r < 50) c.op = CMD_WRITE_RHS;
        else if (r < 55) c.op = CMD_SWEEP;
        else if (r < 75) c.op = CMD_READ_CELL;
        else if (r < 95) c.op = CMD_READ_RESIDUAL;
        else c.op = CMD_UNUSED_LO + CMD_BITS'($urandom_range(0, CMD_UNUSED_HI - CMD_UNUSED_LO));
        c.x      = random_coord(c.op == CMD_WRITE_CELL || c.op == CMD_READ_CELL);
        c.y      = random_coord(c.op == CMD_WRITE_CELL || c.op == CMD_READ_CELL);
        c.z      = random_coord(c.op == CMD_WRITE_CELL || c.op == CMD_READ_CELL);
        c.value  = random_value();
        c.parity = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // offer one command after an idle gap, return at its transaction edge
    task automatic send_command(input t_command c, input int gap);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.cmd    <= c.op;
        cmd_if.x      <= c.x;
        cmd_if.y      <= c.y;
        cmd_if.z      <= c.z;
        cmd_if.value  <= c.value;
        cmd_if.parity <= c.parity;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        sb.note_command(c);
    endtask

    task automatic send_fields(input logic [CMD_BITS-1:0] op, input int x, input int y,
                               input int z, input logic signed [IN_VALUE_BITS-1:0] value,
                               input logic parity);
        t_command c;
        c.op     = op;
        c.x      = IN_CRD_BITS'(x);
        c.y      = IN_CRD_BITS'(y);
        c.z      = IN_CRD_BITS'(z);
        c.value  = value;
        c.parity = parity;
        send_command(c, pick_gap());
    endtask

    // receiver: random stalls plus one long hold on request
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                sb.check_response(rsp_if.data, rsp_if.error);
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                holds_done++;
                stall_left = HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end else if (no_idle) begin
                rsp_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    rsp_if.ready <= 1'b1;
                end else if (r < 95) begin
                    stall_left = $urandom_range(0, 2);
                    rsp_if.ready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(9, 49);
                    rsp_if.ready <= 1'b0;
                end
            end
        end
    end

    // run limit
    initial begin
        #20_000_000;
        $display("brick_red_black_poisson_smoother_top test failed");
        $finish;
    end

    // reset, directed commands, random commands, drain and verdict
    initial begin
        int       burst_left;
        t_command c;
        cmd_if.valid  = 1'b0;
        cmd_if.cmd    = CMD_WRITE_CELL;
        cmd_if.x      = '0;
        cmd_if.y      = '0;
        cmd_if.z      = '0;
        cmd_if.value  = '0;
        cmd_if.parity = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner cell with all six neighbours and rhs at full scale
        send_fields(CMD_WRITE_CELL, -1, 0, 0, Q_MAX, 1'b0);
        send_fields(CMD_WRITE_CELL, 1, 0, 0, Q_MAX, 1'b0);
        send_fields(CMD_WRITE_CELL, 0, -1, 0, Q_MAX, 1'b0);
        send_fields(CMD_WRITE_CELL, 0, 1, 0, Q_MAX, 1'b0);
        send_fields(CMD_WRITE_CELL, 0, 0, -1, Q_MAX, 1'b0);
        send_fields(CMD_WRITE_CELL, 0, 0, 1, Q_MAX, 1'b0);
        send_fields(CMD_WRITE_CELL, 0, 0, 0, Q_MIN, 1'b1);
        send_fields(CMD_WRITE_RHS, 0, 0, 0, Q_MAX, 1'b1);
        // residual and sweep both saturate high
        send_fields(CMD_READ_RESIDUAL, 0, 0, 0, 32'sd0, 1'b1);
        send_fields(CMD_SWEEP, 0, 0, 0, Q_MIN, 1'b0);
        send_fields(CMD_READ_CELL, 0, 0, 0, 32'sd0, 1'b0);
        // far halo corner and the opposite colour
        send_fields(CMD_WRITE_CELL, BRICK_SIZE, BRICK_SIZE, BRICK_SIZE, Q_MIN, 1'b0);
        send_fields(CMD_READ_CELL, BRICK_SIZE, BRICK_SIZE, BRICK_SIZE, 32'sd0, 1'b0);
        send_fields(CMD_READ_CELL, -1, -1, -1, 32'sd0, 1'b1);
        send_fields(CMD_WRITE_RHS, BRICK_SIZE - 1, BRICK_SIZE - 1, BRICK_SIZE - 1, Q_MIN, 1'b0);
        send_fields(CMD_SWEEP, -16, 15, -1, Q_MAX, 1'b1);
        send_fields(CMD_READ_RESIDUAL, BRICK_SIZE - 1, BRICK_SIZE - 1, BRICK_SIZE - 1,
                    32'sd0, 1'b0);
        // out-of-range coordinates
        send_fields(CMD_WRITE_CELL, BRICK_SIZE + 1, 0, 0, 32'sd5, 1'b0);
        send_fields(CMD_WRITE_CELL, -16, 15, 0, 32'sd7, 1'b1);
        send_fields(CMD_WRITE_RHS, 0, 0, BRICK_SIZE, 32'sd9, 1'b0);
        send_fields(CMD_READ_RESIDUAL, -1, 0, 0, 32'sd0, 1'b0);
        send_fields(CMD_READ_CELL, 0, -2, 0, 32'sd0, 1'b1);
        // unused command codes
        send_fields(CMD_UNUSED_LO, 0, 0, 0, Q_MAX, 1'b0);
        send_fields(CMD_UNUSED_LO + 3'd1, 1, 1, 1, Q_MIN, 1'b1);
        send_fields(CMD_UNUSED_HI, -1, BRICK_SIZE, 3, 32'sd1, 1'b0);

        // random traffic with one long receiver hold and an idle-free stretch
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 60) begin
                hold_request = 1'b1;
                burst_left = BURST_ITEMS;
            end
            no_idle = (n >= 150 && n < 190);
            c = random_command(burst_left == 0);
            if (burst_left > 0) begin
                burst_left--;
                send_command(c, 0);
            end else begin
                send_command(c, pick_gap());
            end
        end
        cmd_if.valid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d commands: %0d cell writes, %0d rhs writes, %0d half-sweeps, %0d cell reads",
                 sb.op_count.sum(), sb.op_count[CMD_WRITE_CELL], sb.op_count[CMD_WRITE_RHS],
                 sb.op_count[CMD_SWEEP], sb.op_count[CMD_READ_CELL]);
        $display("%0d residual reads, %0d error responses, %0d long output holds, %0d mismatches",
                 sb.op_count[CMD_READ_RESIDUAL], sb.error_count, holds_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("brick_red_black_poisson_smoother_top test passed");
        end else begin
            $display("brick_red_black_poisson_smoother_top test failed");
        end
        $finish;
    end

endmodule

// ----- brick_red_black_poisson_smoother_top.f -----
rtl/rbgs_pkg.sv
rtl/rbgs_cmd_if.sv
rtl/rbgs_rsp_if.sv
rtl/brick_red_black_poisson_smoother_top.sv
sim/brick_red_black_poisson_smoother_top_tb.sv
